// ===== rtl/core/mpq_pkg.sv =====
// Shared types and constants of the min priority queue.
package mpq_pkg;

   localparam int CAPACITY_DEFAULT  = 64;
   localparam int KEY_WIDTH_DEFAULT = 32;

   localparam int VALUE_W = 32;
   localparam int COUNT_W = 7;
   localparam int ERROR_W = 2;

   typedef logic [ERROR_W-1:0] error_type;
   localparam error_type ERR_OK    = 2'd0;
   localparam error_type ERR_FULL  = 2'd1;
   localparam error_type ERR_EMPTY = 2'd2;

   typedef logic opcode_type;
   localparam opcode_type OP_INSERT = 1'b0;
   localparam opcode_type OP_POP    = 1'b1;

   typedef struct packed {
      logic insert_en;
      logic pop_en;
   } cell_ctrl_type;

endpackage

// ===== rtl/core/mpq_cell.sv =====
// One cell of the sorted key chain: holds one key, shifts right on insert, left on pop.
module mpq_cell #(
   parameter int KEY_WIDTH = mpq_pkg::KEY_WIDTH_DEFAULT
) (
   input  logic                   clock,
   input  mpq_pkg::cell_ctrl_type ctrl,
   input  logic [KEY_WIDTH-1:0]   new_key,
   input  logic                   occupied,
   input  logic                   left_keep,
   input  logic [KEY_WIDTH-1:0]   left_key,
   input  logic [KEY_WIDTH-1:0]   right_key,
   output logic                   keep,
   output logic [KEY_WIDTH-1:0]   key
);

   logic [KEY_WIDTH-1:0] key_ff;
   logic [KEY_WIDTH-1:0] key_in;

   assign keep = occupied && (key_ff <= new_key);
   assign key  = key_ff;

   always_comb begin
      key_in = key_ff;
      priority if (ctrl.insert_en) begin
         priority if (keep) begin
            key_in = key_ff;
         end else if (left_keep) begin
            key_in = new_key;
         end else begin
            key_in = left_key;
         end
      end else if (ctrl.pop_en) begin
         key_in = right_key;
      end
   end

   always_ff @(posedge clock) begin
      key_ff <= key_in;
   end

endmodule

// ===== rtl/core/min_priority_queue_top.sv =====
// Min priority queue built from a chain of sorted key cells.
// Each taken command gives one registered result beat, through pending_ff and then rsp_valid.
// busy is high for the cycle after a take, so commands are not taken back to back.
// The cell chain registers an insert or pop in its key registers; the minimum sits in cell 0.
// Synchronous active-high reset empties the queue; results cannot be stalled.
module min_priority_queue_top #(
   parameter int CAPACITY  = mpq_pkg::CAPACITY_DEFAULT,
   parameter int KEY_WIDTH = mpq_pkg::KEY_WIDTH_DEFAULT
) (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          start,
   output logic                          busy,
   input  mpq_pkg::opcode_type           req_opcode,
   input  logic [mpq_pkg::VALUE_W-1:0]   req_value,
   output logic                          rsp_valid,
   output logic [mpq_pkg::VALUE_W-1:0]   rsp_min_value,
   output logic                          rsp_queue_empty,
   output logic [mpq_pkg::COUNT_W-1:0]   rsp_entry_count,
   output mpq_pkg::error_type            rsp_error_code
);

   localparam int CNT_W = $clog2(CAPACITY + 1);
   localparam int EXT_W = KEY_WIDTH + mpq_pkg::VALUE_W;
   localparam int CEXT_W = CNT_W + mpq_pkg::COUNT_W;

   logic [CNT_W-1:0]         count_ff;
   logic [CNT_W-1:0]         count_in;
   logic                     pending_ff;
   mpq_pkg::error_type       err_ff;
   mpq_pkg::error_type       err_in;
   logic                     rsp_valid_ff;
   logic [mpq_pkg::VALUE_W-1:0] rsp_min_value_ff;
   logic                     rsp_queue_empty_ff;
   logic [mpq_pkg::COUNT_W-1:0] rsp_entry_count_ff;
   mpq_pkg::error_type       rsp_error_code_ff;

   logic                     accept;
   logic                     is_full;
   logic                     is_empty;
   mpq_pkg::cell_ctrl_type   ctrl;
   logic [EXT_W-1:0]         value_ext;
   logic [KEY_WIDTH-1:0]     new_key;
   logic [EXT_W-1:0]         min_ext;
   logic [CEXT_W-1:0]        count_ext;

   logic [CAPACITY-1:0]      occupied;
   logic [CAPACITY-1:0]      keep;
   logic [KEY_WIDTH-1:0]     cell_key [CAPACITY];

   assign accept    = start && !busy;
   assign is_full   = (count_ff == CNT_W'(CAPACITY));
   assign is_empty  = (count_ff == '0);
   assign value_ext = EXT_W'(req_value);
   assign new_key   = value_ext[KEY_WIDTH-1:0];

   always_comb begin
      ctrl.insert_en = 1'b0;
      ctrl.pop_en    = 1'b0;
      err_in         = mpq_pkg::ERR_OK;
      count_in       = count_ff;
      if (accept) begin
         unique case (req_opcode)
            mpq_pkg::OP_INSERT: begin
               if (is_full) begin
                  err_in = mpq_pkg::ERR_FULL;
               end else begin
                  ctrl.insert_en = 1'b1;
                  count_in       = count_ff + CNT_W'(1);
               end
            end
            mpq_pkg::OP_POP: begin
               if (is_empty) begin
                  err_in = mpq_pkg::ERR_EMPTY;
               end else begin
                  ctrl.pop_en = 1'b1;
                  count_in    = count_ff - CNT_W'(1);
               end
            end
            default: begin
               err_in = mpq_pkg::ERR_OK;
            end
         endcase
      end
   end

   for (genvar i = 0; i < CAPACITY; i++) begin : g_cell
      logic                 left_keep;
      logic [KEY_WIDTH-1:0] left_key;
      logic [KEY_WIDTH-1:0] right_key;

      assign occupied[i] = (count_ff > CNT_W'(i));

      if (i == 0) begin : g_head
         assign left_keep = 1'b1;
         assign left_key  = new_key;
      end else begin : g_body
         assign left_keep = keep[i-1];
         assign left_key  = cell_key[i-1];
      end

      if (i == CAPACITY - 1) begin : g_tail
         assign right_key = cell_key[i];
      end else begin : g_inner
         assign right_key = cell_key[i+1];
      end

      mpq_cell #(
         .KEY_WIDTH (KEY_WIDTH)
      ) u_cell (
         .clock     (clock),
         .ctrl      (ctrl),
         .new_key   (new_key),
         .occupied  (occupied[i]),
         .left_keep (left_keep),
         .left_key  (left_key),
         .right_key (right_key),
         .keep      (keep[i]),
         .key       (cell_key[i])
      );
   end

   assign min_ext   = EXT_W'(cell_key[0]);
   assign count_ext = CEXT_W'(count_ff);

   always_ff @(posedge clock) begin
      if (reset) begin
         count_ff     <= '0;
         pending_ff   <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         count_ff     <= count_in;
         pending_ff   <= accept;
         rsp_valid_ff <= pending_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (accept) begin
         err_ff <= err_in;
      end
      if (pending_ff) begin
         rsp_min_value_ff   <= is_empty ? '0 : min_ext[mpq_pkg::VALUE_W-1:0];
         rsp_queue_empty_ff <= is_empty;
         rsp_entry_count_ff <= count_ext[mpq_pkg::COUNT_W-1:0];
         rsp_error_code_ff  <= err_ff;
      end
   end

   assign busy            = pending_ff;
   assign rsp_valid       = rsp_valid_ff;
   assign rsp_min_value   = rsp_min_value_ff;
   assign rsp_queue_empty = rsp_queue_empty_ff;
   assign rsp_entry_count = rsp_entry_count_ff;
   assign rsp_error_code  = rsp_error_code_ff;

`ifndef SYNTHESIS
   a_beat_follows: assert property (@(posedge clock) disable iff (reset)
      (start && !busy) |-> ##2 rsp_valid)
      else $error("no result beat two cycles after a take");

   a_empty_beat: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && rsp_queue_empty) |-> (rsp_min_value == '0 && rsp_entry_count == '0))
      else $error("empty result beat carries a key or count");

   a_full_reject: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && rsp_error_code == mpq_pkg::ERR_FULL) |-> (count_ff == CNT_W'(CAPACITY)))
      else $error("full rejection while queue not full");

   a_head_sorted: assert property (@(posedge clock) disable iff (reset)
      (count_ff > CNT_W'(1)) |-> (cell_key[0] <= cell_key[1]))
      else $error("head cells out of order");
`endif

endmodule

// ===== tb/min_priority_queue_top_test.sv =====
`timescale 1ns / 1ps
// Self-checking testbench for the min priority queue: directed and random insert and pop beats.
module min_priority_queue_top_test;

   localparam int CAPACITY    = mpq_pkg::CAPACITY_DEFAULT;
   localparam int VALUE_W     = mpq_pkg::VALUE_W;
   localparam int COUNT_W     = mpq_pkg::COUNT_W;
   localparam int ITEM_TARGET = 850;
   localparam int IDLE_PCT    = 31;
   localparam int STALL_LIMIT = 1000;
   localparam int TAIL_CYCLES = 8;
   localparam int CALM_FIRST  = 400;
   localparam int CALM_LAST   = 560;

   typedef struct {
      mpq_pkg::opcode_type opcode;
      logic [VALUE_W-1:0]  value;
      bit                  wait_drain;
   } command_type;

   typedef struct {
      logic [VALUE_W-1:0] min_value;
      logic               queue_empty;
      logic [COUNT_W-1:0] entry_count;
      mpq_pkg::error_type error_code;
   } queue_status_type;

   logic                clock = 1'b0;
   logic                reset = 1'b1;
   logic                start = 1'b0;
   logic                busy;
   mpq_pkg::opcode_type req_opcode = mpq_pkg::OP_INSERT;
   logic [VALUE_W-1:0]  req_value = '0;
   logic                rsp_valid;
   logic [VALUE_W-1:0]  rsp_min_value;
   logic                rsp_queue_empty;
   logic [COUNT_W-1:0]  rsp_entry_count;
   mpq_pkg::error_type  rsp_error_code;

   command_type         command_queue[$];
   queue_status_type    expected_status[$];
   logic [VALUE_W-1:0]  model_keys[$];
   int                  mismatch_count = 0;
   int                  stall_cycles = 0;
   int                  sent_count = 0;
   int                  queued_total = 0;
   int                  plan_count = 0;
   bit                  drain_next = 1'b0;
   bit                  beat_taken = 1'b0;

   min_priority_queue_top #(
      .CAPACITY (CAPACITY),
      .KEY_WIDTH(mpq_pkg::KEY_WIDTH_DEFAULT)
   ) u_top (
      .clock          (clock),
      .reset          (reset),
      .start          (start),
      .busy           (busy),
      .req_opcode     (req_opcode),
      .req_value      (req_value),
      .rsp_valid      (rsp_valid),
      .rsp_min_value  (rsp_min_value),
      .rsp_queue_empty(rsp_queue_empty),
      .rsp_entry_count(rsp_entry_count),
      .rsp_error_code (rsp_error_code)
   );

   initial begin
      forever #1 clock = ~clock;
   end

   initial begin
      repeat (11) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;
   end

   task automatic report_mismatch(string field, longint unsigned got, longint unsigned want);
      $display("%0t: mismatch on %s: got %0h, want %0h", $realtime, field, got, want);
      mismatch_count++;
   endtask

   function automatic int lowest_slot();
      int best;
      best = 0;
      for (int i = 1; i < model_keys.size(); i++)
         if (model_keys[i] < model_keys[best]) best = i;
      return best;
   endfunction

   function automatic queue_status_type apply_queue_op(mpq_pkg::opcode_type op,
                                                       logic [VALUE_W-1:0] key);
      queue_status_type status;
      status.error_code = mpq_pkg::ERR_OK;
      if (op == mpq_pkg::OP_INSERT) begin
         if (model_keys.size() >= CAPACITY) status.error_code = mpq_pkg::ERR_FULL;
         else model_keys.push_back(key);
      end else if (model_keys.size() == 0) begin
         status.error_code = mpq_pkg::ERR_EMPTY;
      end else begin
         model_keys.delete(lowest_slot());
      end
      status.queue_empty = (model_keys.size() == 0);
      status.min_value   = status.queue_empty ? '0 : model_keys[lowest_slot()];
      status.entry_count = COUNT_W'(model_keys.size());
      return status;
   endfunction

   function automatic logic [VALUE_W-1:0] rand_key();
      case ($urandom_range(7))
         0:       return '0;
         1:       return '1;
         2:       return VALUE_W'(1) << $urandom_range(VALUE_W - 1);
         3, 4:    return VALUE_W'($urandom_range(15));
         default: return VALUE_W'($urandom());
      endcase
   endfunction

   function automatic void add_command(mpq_pkg::opcode_type op, logic [VALUE_W-1:0] key);
      command_type cmd;
      cmd.opcode     = op;
      cmd.value      = key;
      cmd.wait_drain = drain_next;
      drain_next     = 1'b0;
      command_queue.push_back(cmd);
      queued_total++;
      if (op == mpq_pkg::OP_INSERT && plan_count < CAPACITY) plan_count++;
      if (op == mpq_pkg::OP_POP && plan_count > 0) plan_count--;
   endfunction

   always @(posedge clock) begin
      queue_status_type want;
      if (reset) begin
         beat_taken = 1'b0;
      end else begin
         beat_taken = start && !busy;
         if (rsp_valid) begin
            if (expected_status.size() == 0) begin
               report_mismatch("unexpected beat", rsp_entry_count, 0);
            end else begin
               want = expected_status.pop_front();
               if (rsp_min_value !== want.min_value)
                  report_mismatch("min_value", rsp_min_value, want.min_value);
               if (rsp_queue_empty !== want.queue_empty)
                  report_mismatch("queue_empty", rsp_queue_empty, want.queue_empty);
               if (rsp_entry_count !== want.entry_count)
                  report_mismatch("entry_count", rsp_entry_count, want.entry_count);
               if (rsp_error_code !== want.error_code)
                  report_mismatch("error_code", rsp_error_code, want.error_code);
            end
         end
         if (beat_taken) expected_status.push_back(apply_queue_op(req_opcode, req_value));
         stall_cycles = (beat_taken || rsp_valid) ? 0 : stall_cycles + 1;
      end
   end

   always @(negedge clock) begin
      command_type cmd;
      bit          calm;
      if (!reset && (!start || beat_taken)) begin
         calm = (sent_count >= CALM_FIRST && sent_count < CALM_LAST);
         if (command_queue.size() > 0
             && !(command_queue[0].wait_drain && expected_status.size() > 0)
             && (calm || $urandom_range(99) >= IDLE_PCT)) begin
            cmd = command_queue.pop_front();
            start      <= 1'b1;
            req_opcode <= cmd.opcode;
            req_value  <= cmd.value;
            sent_count++;
         end else begin
            start      <= 1'b0;
            req_opcode <= mpq_pkg::opcode_type'($urandom_range(1));
            req_value  <= VALUE_W'($urandom());
         end
      end
   end

   initial begin
      while (stall_cycles < STALL_LIMIT) @(negedge clock);
      $display("CHECK FAILED");
      $finish;
   end

   initial begin
      add_command(mpq_pkg::OP_POP, 32'hFFFF_FFFF);
      add_command(mpq_pkg::OP_INSERT, 32'hFFFF_FFFF);
      add_command(mpq_pkg::OP_INSERT, 32'h8000_0000);
      add_command(mpq_pkg::OP_INSERT, 32'h0000_0000);
      add_command(mpq_pkg::OP_INSERT, 32'h0000_0001);
      add_command(mpq_pkg::OP_INSERT, 32'h0000_0001);
      add_command(mpq_pkg::OP_POP, 32'h0000_0000);
      add_command(mpq_pkg::OP_POP, 32'h5555_5555);
      add_command(mpq_pkg::OP_POP, 32'hAAAA_AAAA);
      add_command(mpq_pkg::OP_POP, 32'h0000_0000);
      add_command(mpq_pkg::OP_POP, 32'hFFFF_FFFF);
      add_command(mpq_pkg::OP_POP, 32'h0000_0000);
      add_command(mpq_pkg::OP_INSERT, 32'h0000_0007);
      add_command(mpq_pkg::OP_INSERT, 32'h0000_0007);
      add_command(mpq_pkg::OP_POP, 32'h0000_0000);
      add_command(mpq_pkg::OP_POP, 32'h0000_0000);
      drain_next = 1'b1;
      while (queued_total < ITEM_TARGET) begin
         case ($urandom_range(9))
            0, 1: begin
               while (plan_count < CAPACITY) add_command(mpq_pkg::OP_INSERT, rand_key());
               repeat ($urandom_range(1, 3)) add_command(mpq_pkg::OP_INSERT, rand_key());
            end
            2: begin
               while (plan_count > 0) add_command(mpq_pkg::OP_POP, VALUE_W'($urandom()));
               repeat ($urandom_range(1, 2))
                  add_command(mpq_pkg::OP_POP, VALUE_W'($urandom()));
            end
            default: begin
               repeat ($urandom_range(5, 30))
                  add_command(($urandom_range(99) < 55) ? mpq_pkg::OP_INSERT : mpq_pkg::OP_POP,
                              rand_key());
            end
         endcase
         if ($urandom_range(7) == 0) drain_next = 1'b1;
      end

      @(negedge clock);
      while (reset || command_queue.size() > 0 || start || expected_status.size() > 0)
         @(negedge clock);
      repeat (TAIL_CYCLES) @(negedge clock);
      if (mismatch_count == 0 && expected_status.size() == 0)
         $display("CHECK OK");
      else
         $display("CHECK FAILED");
      $finish;
   end

endmodule
